[design/izn_pkg.sv]
package izn_pkg;

  typedef struct packed {
    logic signed [31:0] membrane_v;
    logic signed [31:0] recovery_u;
    logic signed [31:0] input_current;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] membrane_after;
    logic signed [31:0] recovery_after;
    logic signed [31:0] voltage_slope;
    logic signed [31:0] recovery_slope;
    logic               spiked;
  } out_word_t;

  typedef struct packed {
    logic        [1:0]  model_kind;
    logic signed [31:0] peak_voltage;
    logic signed [31:0] reset_voltage;
    logic signed [31:0] recovery_jump;
    logic signed [31:0] rest_voltage;
    logic signed [31:0] threshold_voltage;
    logic signed [31:0] recovery_rate;
    logic signed [31:0] recovery_sensitivity;
  } cfg_t;

  // reset stage output: values after the spike reset
  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] u;
    logic signed [31:0] cur;
    logic               spike;
  } reset_word_t;

  localparam logic [1:0] KIND_STANDARD = 2'd0;
  localparam logic [1:0] KIND_SAT_REC  = 2'd1;
  localparam logic [1:0] KIND_CUBIC    = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic [2:0] REG_MODEL_KIND  = 3'd0;
  localparam logic [2:0] REG_PEAK        = 3'd1;
  localparam logic [2:0] REG_RESET_V     = 3'd2;
  localparam logic [2:0] REG_REC_JUMP    = 3'd3;
  localparam logic [2:0] REG_REST_V      = 3'd4;
  localparam logic [2:0] REG_THRESH_V    = 3'd5;
  localparam logic [2:0] REG_REC_RATE    = 3'd6;
  localparam logic [2:0] REG_REC_SENS    = 3'd7;

  // Q15.16 constants
  localparam logic signed [31:0] C_TENTH      = 32'sd6554;
  localparam logic signed [31:0] C_V_BASE     = -32'sd3473408;
  localparam logic signed [31:0] C_V_GAIN     = 32'sd2621;
  localparam logic signed [32:0] C_U_STEP     = 33'sd1310720;
  localparam logic signed [31:0] C_U_CAP      = 32'sd43909120;
  localparam logic signed [31:0] C_CUBE_FLOOR = -32'sd3604480;
  localparam logic signed [31:0] C_CUBE_GAIN  = 32'sd1638;
  localparam logic signed [31:0] C_FIFTH      = 32'sd13107;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = -32'sh8000_0000;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? S32_MIN : S32_MAX;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // Q15.16 product, round half up, saturate
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] prod;
    logic signed [47:0] sh;
    logic signed [31:0] r;
    prod = a * b;
    prod = prod + 64'sd32768;
    sh = prod[63:16];
    if (sh > 48'sh0000_7FFF_FFFF) begin
      r = S32_MAX;
    end else if (sh < -48'sh0000_8000_0000) begin
      r = S32_MIN;
    end else begin
      r = sh[31:0];
    end
    return r;
  endfunction

endpackage

[design/izn_spike_reset.sv]
module izn_spike_reset import izn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        up_valid,
  output logic        up_ready,
  input  in_word_t    up_word,
  output logic        dn_valid,
  input  logic        dn_ready,
  output reset_word_t dn_word
);

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] u;
    logic signed [31:0] cur;
    logic signed [31:0] p_tenth;
    logic signed [31:0] p_gain;
  } prod_word_t;

  logic        a_vld_r, b_vld_r;
  logic        en_a, en_b;
  prod_word_t  a_r, a_nxt;
  reset_word_t b_r, b_nxt;
  logic signed [31:0] thr1;
  logic signed [32:0] nu;

  assign en_b     = !b_vld_r || dn_ready;
  assign en_a     = !a_vld_r || en_b;
  assign up_ready = en_a;
  assign dn_valid = b_vld_r;
  assign dn_word  = b_r;

  always_comb begin
    a_nxt.v       = up_word.membrane_v;
    a_nxt.u       = up_word.recovery_u;
    a_nxt.cur     = up_word.input_current;
    a_nxt.p_tenth = qmul(up_word.recovery_u, C_TENTH);
    a_nxt.p_gain  = qmul(up_word.recovery_u, C_V_GAIN);
  end

  always_comb begin
    thr1 = sat_sub(cfg.peak_voltage, a_r.p_tenth);
    nu = {a_r.u[31], a_r.u} + C_U_STEP;
    b_nxt.v     = a_r.v;
    b_nxt.u     = a_r.u;
    b_nxt.cur   = a_r.cur;
    b_nxt.spike = 1'b0;
    unique case (cfg.model_kind)
      KIND_STANDARD: begin
        if (a_r.v >= cfg.peak_voltage) begin
          b_nxt.spike = 1'b1;
          b_nxt.v     = cfg.reset_voltage;
          b_nxt.u     = sat_add(a_r.u, cfg.recovery_jump);
        end
      end
      KIND_SAT_REC: begin
        if (a_r.v >= thr1) begin
          b_nxt.spike = 1'b1;
          b_nxt.v     = sat_add(C_V_BASE, a_r.p_gain);
          // nu below the cap always fits in 32 bits
          b_nxt.u     = (nu < $signed({C_U_CAP[31], C_U_CAP})) ? nu[31:0] : C_U_CAP;
        end
      end
      KIND_CUBIC: begin
        if (a_r.v >= cfg.peak_voltage) begin
          b_nxt.spike = 1'b1;
          b_nxt.v     = cfg.reset_voltage;
        end
      end
      KIND_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (en_a) a_vld_r <= up_valid;
      if (en_b) b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) a_r <= a_nxt;
    if (en_b) b_r <= b_nxt;
  end

endmodule

[design/izn_slope.sv]
module izn_slope import izn_pkg::*; #(
  parameter int K_OVER_CAP = 459,
  parameter int INV_CAP    = 655
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        up_valid,
  output logic        up_ready,
  input  reset_word_t up_word,
  output logic        dn_valid,
  input  logic        dn_ready,
  output out_word_t   dn_word
);

  localparam logic signed [31:0] KC = 32'(K_OVER_CAP);
  localparam logic signed [31:0] IC = 32'(INV_CAP);

  typedef struct packed {
    reset_word_t        rw;
    logic signed [31:0] dv;
    logic signed [31:0] dt;
    logic signed [31:0] dc;
    logic               cube_on;
    logic signed [31:0] iu;
  } s1_t;

  typedef struct packed {
    reset_word_t        rw;
    logic signed [31:0] q;
    logic signed [31:0] sq;
    logic signed [31:0] bt;
    logic signed [31:0] iq;
    logic signed [31:0] dc;
    logic               cube_on;
  } s2_t;

  typedef struct packed {
    reset_word_t        rw;
    logic signed [31:0] kq;
    logic signed [31:0] cube;
    logic signed [31:0] ubt;
    logic signed [31:0] iq;
    logic               cube_on;
  } s3_t;

  typedef struct packed {
    reset_word_t        rw;
    logic signed [31:0] vslope;
    logic signed [31:0] target;
    logic signed [31:0] us0;
  } s4_t;

  typedef struct packed {
    reset_word_t        rw;
    logic signed [31:0] vslope;
    logic signed [31:0] tu;
    logic signed [31:0] us0;
  } s5_t;

  logic [5:0] vld_r;
  logic [5:0] en;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  out_word_t s6_r, s6_nxt;

  // a stage moves when it is empty or the next one moves
  assign en[5] = !vld_r[5] || dn_ready;
  assign en[4] = !vld_r[4] || en[5];
  assign en[3] = !vld_r[3] || en[4];
  assign en[2] = !vld_r[2] || en[3];
  assign en[1] = !vld_r[1] || en[2];
  assign en[0] = !vld_r[0] || en[1];

  assign up_ready = en[0];
  assign dn_valid = vld_r[5];
  assign dn_word  = s6_r;

  always_comb begin
    s1_nxt.rw      = up_word;
    s1_nxt.dv      = sat_sub(up_word.v, cfg.rest_voltage);
    s1_nxt.dt      = sat_sub(up_word.v, cfg.threshold_voltage);
    s1_nxt.dc      = sat_sub(up_word.v, C_CUBE_FLOOR);
    s1_nxt.cube_on = up_word.v >= C_CUBE_FLOOR;
    s1_nxt.iu      = sat_sub(up_word.cur, up_word.u);
  end

  always_comb begin
    s2_nxt.rw      = s1_r.rw;
    s2_nxt.q       = qmul(s1_r.dv, s1_r.dt);
    s2_nxt.sq      = qmul(s1_r.dc, s1_r.dc);
    s2_nxt.bt      = qmul(cfg.recovery_sensitivity, s1_r.dv);
    s2_nxt.iq      = qmul(s1_r.iu, IC);
    s2_nxt.dc      = s1_r.dc;
    s2_nxt.cube_on = s1_r.cube_on;
  end

  always_comb begin
    s3_nxt.rw      = s2_r.rw;
    s3_nxt.kq      = qmul(s2_r.q, KC);
    s3_nxt.cube    = qmul(s2_r.sq, s2_r.dc);
    s3_nxt.ubt     = sat_sub(s2_r.bt, s2_r.rw.u);
    s3_nxt.iq      = s2_r.iq;
    s3_nxt.cube_on = s2_r.cube_on;
  end

  always_comb begin
    s4_nxt.rw     = s3_r.rw;
    s4_nxt.vslope = sat_add(s3_r.kq, s3_r.iq);
    s4_nxt.target = s3_r.cube_on ? qmul(s3_r.cube, C_CUBE_GAIN) : '0;
    s4_nxt.us0    = qmul(cfg.recovery_rate, s3_r.ubt);
  end

  always_comb begin
    s5_nxt.rw     = s4_r.rw;
    s5_nxt.vslope = s4_r.vslope;
    s5_nxt.tu     = sat_sub(s4_r.target, s4_r.rw.u);
    s5_nxt.us0    = s4_r.us0;
  end

  always_comb begin
    s6_nxt.membrane_after = s5_r.rw.v;
    s6_nxt.recovery_after = s5_r.rw.u;
    s6_nxt.voltage_slope  = s5_r.vslope;
    s6_nxt.recovery_slope = (cfg.model_kind == KIND_CUBIC) ? qmul(s5_r.tu, C_FIFTH)
                                                           : s5_r.us0;
    s6_nxt.spiked         = s5_r.rw.spike;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
      if (en[4]) vld_r[4] <= vld_r[3];
      if (en[5]) vld_r[5] <= vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
    if (en[1]) s2_r <= s2_nxt;
    if (en[2]) s3_r <= s3_nxt;
    if (en[3]) s4_r <= s4_nxt;
    if (en[4]) s5_r <= s5_nxt;
    if (en[5]) s6_r <= s6_nxt;
  end

endmodule

[design/izhikevich_neuron_derivative_top.sv]
// channel | direction | handshake          | word
// in      | input     | in_valid/in_ready   | in_word_t  (v, u, current)
// out     | output    | out_valid/out_ready | out_word_t (v', u', dv, du, spiked)
// cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// one word per cycle sustained while out_ready stays high
// pipeline depth set by the chain qmul(q, k), then a*(b*dv - u) or the cubic target
// rst_n clears all valid bits and loads the register defaults
// each stage holds while full and its successor stalls; bubbles close up
module izhikevich_neuron_derivative_top import izn_pkg::*; #(
  parameter int K_OVER_CAP = 459,
  parameter int INV_CAP    = 655
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t        cfg_r;
  logic        mid_valid, mid_ready;
  reset_word_t mid_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.model_kind           <= KIND_STANDARD;
      cfg_r.peak_voltage         <= 32'sd2293760;
      cfg_r.reset_voltage        <= -32'sd3276800;
      cfg_r.recovery_jump        <= 32'sd6553600;
      cfg_r.rest_voltage         <= -32'sd3932160;
      cfg_r.threshold_voltage    <= -32'sd2621440;
      cfg_r.recovery_rate        <= 32'sd1966;
      cfg_r.recovery_sensitivity <= -32'sd131072;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODEL_KIND: cfg_r.model_kind           <= cfg_wdata[1:0];
        REG_PEAK:       cfg_r.peak_voltage         <= cfg_wdata;
        REG_RESET_V:    cfg_r.reset_voltage        <= cfg_wdata;
        REG_REC_JUMP:   cfg_r.recovery_jump        <= cfg_wdata;
        REG_REST_V:     cfg_r.rest_voltage         <= cfg_wdata;
        REG_THRESH_V:   cfg_r.threshold_voltage    <= cfg_wdata;
        REG_REC_RATE:   cfg_r.recovery_rate        <= cfg_wdata;
        REG_REC_SENS:   cfg_r.recovery_sensitivity <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  izn_spike_reset u_reset (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_word  (in_word),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_word  (mid_word)
  );

  izn_slope #(
    .K_OVER_CAP (K_OVER_CAP),
    .INV_CAP    (INV_CAP)
  ) u_slope (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_word  (mid_word),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_word  (out_word)
  );

`ifndef SYNTH
  // the pipe only backs up when the output word is waiting
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while output register empty");

  a_reset_voltage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.spiked &&
     (cfg_r.model_kind == KIND_STANDARD || cfg_r.model_kind == KIND_CUBIC))
    |-> out_word.membrane_after == cfg_r.reset_voltage)
    else $error("spike word without reset voltage");

  a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg_r.model_kind == KIND_NONE) |-> !out_word.spiked)
    else $error("spike flagged for unused kind");

  a_recovery_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.spiked && cfg_r.model_kind == KIND_SAT_REC)
    |-> out_word.recovery_after <= C_U_CAP)
    else $error("recovery above cap after spike");
`endif

endmodule

[tb/tb_izhikevich_neuron_derivative_top.sv]
`timescale 1ns / 100ps

module tb_izhikevich_neuron_derivative_top;
  import izn_pkg::*;

  localparam int K_GAIN   = 459;
  localparam int INV_GAIN = 655;

  localparam int LIM_HI = 32'sh7fff_ffff;
  localparam int LIM_LO = 32'sh8000_0000;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // Q15.16 constants of the update
  localparam longint TENTH_Q      = 6554;
  localparam longint V_BASE_Q     = -3473408;
  localparam longint V_GAIN_Q     = 2621;
  localparam longint U_STEP_Q     = 1310720;
  localparam longint U_CAP_Q      = 43909120;
  localparam longint CUBE_FLOOR_Q = -3604480;
  localparam longint CUBE_GAIN_Q  = 1638;
  localparam longint FIFTH_Q      = 13107;

  // extra wait after the scoreboard empties, kept as margin
  localparam int DRAIN_CYCLES = 12;

  class neuron_scoreboard;
    cfg_t      setting;
    out_word_t pending_updates[$];
    int        fails;

    function automatic longint clamp32(longint x);
      if (x > SAT_HI) return SAT_HI;
      if (x < SAT_LO) return SAT_LO;
      return x;
    endfunction

    // rounded half up, then saturated
    function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b + 32768;
      return clamp32(p >>> 16);
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MODEL_KIND: setting.model_kind           = val[1:0];
        REG_PEAK:       setting.peak_voltage         = val;
        REG_RESET_V:    setting.reset_voltage        = val;
        REG_REC_JUMP:   setting.recovery_jump        = val;
        REG_REST_V:     setting.rest_voltage         = val;
        REG_THRESH_V:   setting.threshold_voltage    = val;
        REG_REC_RATE:   setting.recovery_rate        = val;
        REG_REC_SENS:   setting.recovery_sensitivity = val;
        default: ;
      endcase
    endfunction

    function automatic out_word_t predict_update(in_word_t w);
      longint    v, u, cur, peak, reset_v, jump, rest, thr, rate, sens;
      longint    limit, dv, dt, kq, iq, tgt, d, vs, us;
      bit        fired;
      out_word_t r;
      v       = w.membrane_v;
      u       = w.recovery_u;
      cur     = w.input_current;
      peak    = setting.peak_voltage;
      reset_v = setting.reset_voltage;
      jump    = setting.recovery_jump;
      rest    = setting.rest_voltage;
      thr     = setting.threshold_voltage;
      rate    = setting.recovery_rate;
      sens    = setting.recovery_sensitivity;
      fired   = 1'b0;
      case (setting.model_kind)
        KIND_STANDARD: begin
          if (v >= peak) begin
            fired = 1'b1;
            v     = reset_v;
            u     = clamp32(u + jump);
          end
        end
        KIND_SAT_REC: begin
          limit = clamp32(peak - fx_mul(u, TENTH_Q));
          if (v >= limit) begin
            fired = 1'b1;
            v     = clamp32(V_BASE_Q + fx_mul(u, V_GAIN_Q));
            u     = (u + U_STEP_Q < U_CAP_Q) ? u + U_STEP_Q : U_CAP_Q;
          end
        end
        KIND_CUBIC: begin
          if (v >= peak) begin
            fired = 1'b1;
            v     = reset_v;
          end
        end
        default: ;
      endcase
      dv = clamp32(v - rest);
      dt = clamp32(v - thr);
      kq = fx_mul(fx_mul(dv, dt), K_GAIN);
      iq = fx_mul(clamp32(cur - u), INV_GAIN);
      vs = clamp32(kq + iq);
      if (setting.model_kind == KIND_CUBIC) begin
        tgt = 0;
        if (v >= CUBE_FLOOR_Q) begin
          d   = clamp32(v - CUBE_FLOOR_Q);
          tgt = fx_mul(fx_mul(fx_mul(d, d), d), CUBE_GAIN_Q);
        end
        us = fx_mul(clamp32(tgt - u), FIFTH_Q);
      end else begin
        us = fx_mul(rate, clamp32(fx_mul(sens, dv) - u));
      end
      r.membrane_after = v[31:0];
      r.recovery_after = u[31:0];
      r.voltage_slope  = vs[31:0];
      r.recovery_slope = us[31:0];
      r.spiked         = fired;
      return r;
    endfunction

    function void take_input(in_word_t w);
      pending_updates.push_back(predict_update(w));
    endfunction

    function void check_update(out_word_t got);
      out_word_t want;
      if (pending_updates.size() == 0) begin
        $error("result word with no input outstanding");
        fails++;
        return;
      end
      want = pending_updates.pop_front();
      if (got.membrane_after !== want.membrane_after) begin
        $error("membrane_after: expected %0d, got %0d", want.membrane_after,
               got.membrane_after);
        fails++;
      end
      if (got.recovery_after !== want.recovery_after) begin
        $error("recovery_after: expected %0d, got %0d", want.recovery_after,
               got.recovery_after);
        fails++;
      end
      if (got.voltage_slope !== want.voltage_slope) begin
        $error("voltage_slope: expected %0d, got %0d", want.voltage_slope,
               got.voltage_slope);
        fails++;
      end
      if (got.recovery_slope !== want.recovery_slope) begin
        $error("recovery_slope: expected %0d, got %0d", want.recovery_slope,
               got.recovery_slope);
        fails++;
      end
      if (got.spiked !== want.spiked) begin
        $error("spiked: expected %0d, got %0d", want.spiked, got.spiked);
        fails++;
      end
    endfunction

    function int waiting();
      return pending_updates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  neuron_scoreboard sb;
  logic [31:0]      cfg_image [8];
  bit               gaps_on;

  izhikevich_neuron_derivative_top #(
    .K_OVER_CAP(K_GAIN),
    .INV_CAP   (INV_GAIN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // results are checked before the same edge's input is logged
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_update(out_word);
      if (in_valid && in_ready) sb.take_input(in_word);
    end
  end

  // receiver: free-running, random, and long stalls
  initial begin : result_sink
    int mode;
    int len;
    out_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 9);
      len  = (mode >= 8) ? $urandom_range(8, 40) : $urandom_range(5, 60);
      repeat (len) begin
        @(posedge clk);
        if (mode < 4) out_ready <= 1'b1;
        else if (mode < 8) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= 1'b0;
      end
    end
  end

  function automatic int q16(int m);
    return m * 65536;
  endfunction

  // mostly plausible millivolt values with random fraction, some noise and edges
  function automatic int pick_value(int lo_mv, int hi_mv);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return q16(int'($urandom_range(0, hi_mv - lo_mv)) + lo_mv)
                       + int'($urandom_range(0, 65535));
    if (r < 85) return $urandom();
    if (r < 92) return int'($urandom_range(0, 131071)) - 65536;
    case ($urandom_range(0, 4))
      0: return LIM_HI;
      1: return LIM_LO;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int next_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input int v, input int u, input int cur);
    int gap;
    in_word  <= in_word_t'{v, u, cur};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    // let the last accepted word reach the scoreboard first
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs();
    wait_drained();
    for (int i = REG_MODEL_KIND; i <= REG_REC_SENS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= cfg_image[i];
      @(posedge clk);
      sb.set_reg(3'(i), cfg_image[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_default_image();
    cfg_image[REG_MODEL_KIND] = {30'd0, KIND_STANDARD};
    cfg_image[REG_PEAK]       = q16(35);
    cfg_image[REG_RESET_V]    = q16(-50);
    cfg_image[REG_REC_JUMP]   = q16(100);
    cfg_image[REG_REST_V]     = q16(-60);
    cfg_image[REG_THRESH_V]   = q16(-40);
    cfg_image[REG_REC_RATE]   = 1966;
    cfg_image[REG_REC_SENS]   = q16(-2);
  endtask

  task automatic set_extremes(input bit top, input logic [1:0] kind);
    cfg_image[REG_MODEL_KIND] = {30'd0, kind};
    cfg_image[REG_PEAK]       = top ? LIM_HI : LIM_LO;
    cfg_image[REG_RESET_V]    = top ? LIM_HI : LIM_LO;
    cfg_image[REG_REC_JUMP]   = top ? LIM_HI : LIM_LO;
    cfg_image[REG_REST_V]     = top ? LIM_LO : LIM_HI;
    cfg_image[REG_THRESH_V]   = top ? LIM_HI : LIM_LO;
    cfg_image[REG_REC_RATE]   = top ? LIM_HI : LIM_LO;
    cfg_image[REG_REC_SENS]   = top ? LIM_LO : LIM_HI;
  endtask

  initial begin : stimulus
    logic [1:0] kind;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MODEL_KIND;
    cfg_wdata <= '0;
    gaps_on   = 1'b1;
    sb        = new();
    // the block comes out of reset with the default registers
    load_default_image();
    for (int i = REG_MODEL_KIND; i <= REG_REC_SENS; i++) sb.set_reg(3'(i), cfg_image[i]);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // standard reset: peak boundary and saturation
    send_word(0, 0, 0);
    send_word(q16(35), 0, q16(10));
    send_word(q16(35) - 1, q16(-14), q16(10));
    send_word(LIM_HI, LIM_HI, LIM_LO);
    send_word(LIM_LO, LIM_LO, LIM_HI);
    send_word(q16(-65), q16(-13), q16(5));

    // unused kind: no reset at all
    cfg_image[REG_MODEL_KIND] = {30'd0, KIND_NONE};
    program_regs();
    send_word(LIM_HI, q16(100), q16(20));

    // recovery-dependent threshold, recovery cap at 670
    cfg_image[REG_MODEL_KIND] = {30'd0, KIND_SAT_REC};
    program_regs();
    send_word(q16(35), 0, 0);
    send_word(q16(-40), q16(700), q16(50));
    send_word(q16(-60), LIM_HI, 0);
    send_word(LIM_HI, LIM_LO, LIM_LO);
    // threshold is exactly 2359300 for u = -10 mV
    send_word(2359300, q16(-10), q16(3));
    send_word(2359299, q16(-10), q16(3));

    // cubic target: above, at and below the -55 floor
    cfg_image[REG_MODEL_KIND] = {30'd0, KIND_CUBIC};
    program_regs();
    send_word(q16(35), q16(-14), q16(10));
    send_word(q16(-70), q16(-14), 0);
    send_word(q16(-55), 0, 0);
    send_word(q16(-55) - 1, 0, 0);

    set_extremes(1'b1, KIND_CUBIC);
    program_regs();
    send_word(LIM_HI, LIM_LO, LIM_HI);
    send_word(LIM_HI - 1, LIM_HI, LIM_LO);
    cfg_image[REG_MODEL_KIND] = {30'd0, KIND_STANDARD};
    program_regs();
    send_word(LIM_HI, LIM_HI, 0);
    send_word(0, LIM_LO, LIM_HI);

    set_extremes(1'b0, KIND_STANDARD);
    program_regs();
    send_word(LIM_LO, LIM_HI, LIM_LO);
    send_word(q16(-65), 0, 0);
    cfg_image[REG_MODEL_KIND] = {30'd0, KIND_SAT_REC};
    program_regs();
    send_word(LIM_LO, 0, 0);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      load_default_image();
      kind = $urandom_range(0, 3);
      // upper bits of the kind word are don't-care
      cfg_image[REG_MODEL_KIND] = ($urandom() & ~32'h3) | {30'd0, kind};
      if (ph != 0) begin
        cfg_image[REG_PEAK]     = pick_value(0, 60);
        cfg_image[REG_RESET_V]  = pick_value(-70, -40);
        cfg_image[REG_REC_JUMP] = pick_value(0, 200);
        cfg_image[REG_REST_V]   = pick_value(-75, -50);
        cfg_image[REG_THRESH_V] = pick_value(-50, -30);
        cfg_image[REG_REC_RATE] = pick_value(0, 0);
        cfg_image[REG_REC_SENS] = pick_value(-3, 3);
      end
      gaps_on = (ph != 3);
      program_regs();
      for (int n = 0; n < 90; n++) begin
        if (ph == 2 && n == 45) wait_drained();
        send_word(pick_value(-90, 60), pick_value(-50, 800), pick_value(-100, 300));
      end
    end

    wait_drained();
    if (sb.fails == 0 && sb.waiting() == 0) begin
      $display("izhikevich_neuron_derivative_top regression: pass");
    end else begin
      $display("izhikevich_neuron_derivative_top regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("izhikevich_neuron_derivative_top regression: fail");
    $finish;
  end

endmodule
